/* sv/adtf_pkg.sv */
package adtf_pkg;

  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_MUL,
    FOP_DIV
  } fop_t;

  localparam int unsigned ADTF_EXP_CAP = 64;

  localparam logic [31:0] F_ZERO  = 32'h0000_0000;
  localparam logic [31:0] F_ONE   = 32'h3F80_0000;
  localparam logic [31:0] F_TEN   = 32'h4120_0000;
  localparam logic [31:0] F_TENTH = 32'h3DCC_CCCD;
  localparam logic [31:0] F_M48   = 32'hC240_0000;
  localparam logic [31:0] F_QNAN  = 32'hFFC0_0000;
  localparam logic [30:0] F_INF   = 31'h7F80_0000;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UP_E  = 8'd69;
  localparam logic [7:0] CH_LO_E  = 8'd101;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  function automatic logic [31:0] small_to_float(logic [5:0] v);
    logic [2:0]  msb;
    logic [22:0] man;
    logic [7:0]  e;
    msb = 3'd0;
    for (int i = 0; i < 6; i++) begin
      if (v[i]) msb = 3'(i);
    end
    man = 23'({17'b0, v} << (5'd23 - 5'(msb)));
    e = 8'd127 + 8'(msb);
    if (v == 6'd0) return F_ZERO;
    return {1'b0, e, man};
  endfunction

endpackage

/* sv/ascii_decimal_to_float_parser.sv */
// Processing: a whitespace, sign, dot or exponent character needs no float operation; an
// integer digit takes a multiply and two adds, a fraction digit a multiply, an add and a
// 27-step divide, all on one shared float unit. A final character then sets up the exponent,
// runs one multiply by ten per exponent step, then a multiply or divide for the scaling.
// Throughput: one character at a time; ready is low while the fpu works or a result waits.
// Reset (rst, synchronous) returns the parser to the leading whitespace phase.
module ascii_decimal_to_float_parser #(
  parameter int unsigned EXP_CAP = adtf_pkg::ADTF_EXP_CAP
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value_bits
);
  import adtf_pkg::*;

  localparam int unsigned EXP_W = $clog2(EXP_CAP + 1);

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_INT,
    PH_FRAC,
    PH_ESIGN,
    PH_EDIG,
    PH_DONE
  } ph_t;

  typedef enum logic [3:0] {
    T_IDLE,
    T_IMUL,
    T_IADD,
    T_ISUB,
    T_FMUL,
    T_FADD,
    T_FDIV,
    T_FIN,
    T_POW,
    T_SCALE,
    T_OUT
  } tstate_t;

  tstate_t          state;
  ph_t              phase, ph_next;
  logic [31:0]      macc, scale, tmp, pw;
  logic             neg, eneg, issued, last_r;
  logic [EXP_W-1:0] exp_acc, exp_next, cnt;
  logic [7:0]       cr;

  logic             dig, spc, is_e, go_int, go_frac, set_neg, set_eneg, exp_dig;
  logic [EXP_W+3:0] e_ext;
  logic             accept;

  logic             f_start, f_done;
  fop_t             f_op;
  logic [31:0]      f_a, f_b, f_y;

  assign in_ready  = state == T_IDLE;
  assign out_valid = state == T_OUT;
  assign accept    = in_valid && in_ready;

  always_comb begin
    dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    spc  = ((char_code >= CH_TAB) && (char_code <= CH_CR)) || (char_code == CH_SPACE);
    is_e = (char_code == CH_UP_E) || (char_code == CH_LO_E);
    ph_next  = phase;
    go_int   = 1'b0;
    go_frac  = 1'b0;
    set_neg  = 1'b0;
    set_eneg = 1'b0;
    exp_dig  = 1'b0;
    unique case (phase)
      PH_SPACE: begin
        if (spc) begin
          ph_next = PH_SPACE;
        end else if (char_code == CH_MINUS) begin
          set_neg = 1'b1;
          ph_next = PH_INT;
        end else if (char_code == CH_PLUS) begin
          ph_next = PH_INT;
        end else if (dig) begin
          go_int  = 1'b1;
          ph_next = PH_INT;
        end else if (char_code == CH_DOT) begin
          ph_next = PH_FRAC;
        end else if (is_e) begin
          ph_next = PH_ESIGN;
        end else begin
          ph_next = PH_DONE;
        end
      end
      PH_INT: begin
        if (dig) go_int = 1'b1;
        else if (char_code == CH_DOT) ph_next = PH_FRAC;
        else if (is_e) ph_next = PH_ESIGN;
        else ph_next = PH_DONE;
      end
      PH_FRAC: begin
        if (dig) go_frac = 1'b1;
        else if (is_e) ph_next = PH_ESIGN;
        else ph_next = PH_DONE;
      end
      PH_ESIGN: begin
        if (char_code == CH_MINUS) begin
          set_eneg = 1'b1;
          ph_next  = PH_EDIG;
        end else if (char_code == CH_PLUS) begin
          ph_next = PH_EDIG;
        end else if (dig) begin
          exp_dig = 1'b1;
          ph_next = PH_EDIG;
        end else begin
          ph_next = PH_DONE;
        end
      end
      PH_EDIG: begin
        if (dig) exp_dig = 1'b1;
        else ph_next = PH_DONE;
      end
      default: ph_next = PH_DONE;
    endcase

    e_ext = (EXP_W+4)'(exp_acc) * (EXP_W+4)'(10)
            + (EXP_W+4)'(char_code[3:0] - CH_ZERO[3:0]);
    if (e_ext > (EXP_W+4)'(EXP_CAP)) exp_next = EXP_W'(EXP_CAP);
    else exp_next = e_ext[EXP_W-1:0];
  end

  always_comb begin
    f_op = FOP_MUL;
    f_a  = macc;
    f_b  = F_TEN;
    case (state)
      T_IADD: begin
        f_op = FOP_ADD;
        f_a  = tmp;
        f_b  = small_to_float(cr[5:0]);
      end
      T_ISUB: begin
        f_op = FOP_ADD;
        f_a  = tmp;
        f_b  = F_M48;
      end
      T_FMUL: begin
        f_a = small_to_float({2'b0, cr[3:0] - CH_ZERO[3:0]});
        f_b = scale;
      end
      T_FADD: begin
        f_op = FOP_ADD;
        f_b  = tmp;
      end
      T_FDIV: begin
        f_op = FOP_DIV;
        f_a  = scale;
      end
      T_POW: f_a = pw;
      T_SCALE: begin
        f_op = eneg ? FOP_DIV : FOP_MUL;
        f_b  = pw;
      end
      default: f_op = FOP_MUL;
    endcase
  end

  assign f_start = !issued && (state == T_IMUL || state == T_IADD || state == T_ISUB ||
                               state == T_FMUL || state == T_FADD || state == T_FDIV ||
                               state == T_POW || state == T_SCALE);

  adtf_fpu u_fpu (
    .clk   (clk),
    .rst   (rst),
    .start (f_start),
    .op    (f_op),
    .a     (f_a),
    .b     (f_b),
    .done  (f_done),
    .y     (f_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= T_IDLE;
      phase   <= PH_SPACE;
      macc    <= F_ZERO;
      scale   <= F_TENTH;
      neg     <= 1'b0;
      eneg    <= 1'b0;
      exp_acc <= '0;
      issued  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      if (f_start) issued <= 1'b1;
      if (f_done) issued <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            cr     <= char_code;
            last_r <= last_char;
            phase  <= ph_next;
            if (set_neg) neg <= 1'b1;
            if (set_eneg) eneg <= 1'b1;
            if (exp_dig) exp_acc <= exp_next;
            if (go_int) state <= T_IMUL;
            else if (go_frac) state <= T_FMUL;
            else if (last_char) state <= T_FIN;
          end
        end
        T_IMUL: begin
          if (f_done) begin
            tmp   <= f_y;
            state <= T_IADD;
          end
        end
        T_IADD: begin
          if (f_done) begin
            tmp   <= f_y;
            state <= T_ISUB;
          end
        end
        T_ISUB: begin
          if (f_done) begin
            macc  <= f_y;
            state <= last_r ? T_FIN : T_IDLE;
          end
        end
        T_FMUL: begin
          if (f_done) begin
            tmp   <= f_y;
            state <= T_FADD;
          end
        end
        T_FADD: begin
          if (f_done) begin
            macc  <= f_y;
            state <= T_FDIV;
          end
        end
        T_FDIV: begin
          if (f_done) begin
            scale <= f_y;
            state <= last_r ? T_FIN : T_IDLE;
          end
        end
        T_FIN: begin
          pw    <= F_ONE;
          cnt   <= exp_acc;
          state <= (exp_acc != '0) ? T_POW : T_SCALE;
        end
        T_POW: begin
          if (f_done) begin
            pw  <= f_y;
            cnt <= cnt - EXP_W'(1);
            if (cnt == EXP_W'(1)) state <= T_SCALE;
          end
        end
        T_SCALE: begin
          if (f_done) begin
            value_bits <= f_y ^ {neg, 31'd0};
            state      <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_ready) begin
            state   <= T_IDLE;
            phase   <= PH_SPACE;
            macc    <= F_ZERO;
            scale   <= F_TENTH;
            neg     <= 1'b0;
            eneg    <= 1'b0;
            exp_acc <= '0;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

/* sv/adtf_fpu.sv */
module adtf_fpu (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  adtf_pkg::fop_t      op,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output logic                done,
  output logic [31:0]         y
);
  import adtf_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE,
    F_UNPACK,
    F_ALIGN,
    F_DIV,
    F_NORM,
    F_DENORM,
    F_ROUND,
    F_DONE
  } fstate_t;

  function automatic logic [5:0] lzc50(logic [49:0] v);
    logic [5:0] n;
    logic       f;
    n = 6'd0;
    f = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!f) begin
        if (v[i]) f = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc24(logic [23:0] v);
    logic [4:0] n;
    logic       f;
    n = 5'd0;
    f = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!f) begin
        if (v[i]) f = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  fstate_t            state;
  fop_t               rop;
  logic [31:0]        ra, rb;
  logic               sgn, zsgn, sub, st, subn;
  logic [23:0]        bsig, ssig, nb;
  logic [7:0]         dsh;
  logic signed [11:0] ex;
  logic [49:0]        sig;
  logic [24:0]        rem;
  logic [26:0]        q;
  logic [4:0]         cnt;

  logic               sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [23:0]        sig_a, sig_b;
  logic signed [11:0] e_a, e_b;
  logic [4:0]         lz_a, lz_b;
  logic [47:0]        prod;
  logic               a_big, special;
  logic [31:0]        spec_y;

  logic [49:0]        al_sm, al_bm, al_sh, al_sum;
  logic               al_lost;
  logic               dv_ge;
  logic [24:0]        dv_r1;
  logic [26:0]        dv_q;
  logic [5:0]         nm_lz;
  logic [11:0]        dn_sh;
  logic [49:0]        dn_v;
  logic               dn_lost;
  logic [24:0]        rd_m;
  logic               rd_up;
  logic signed [11:0] rd_e;

  always_comb begin
    sa     = ra[31];
    sb     = rb[31];
    nan_a  = (ra[30:23] == 8'hFF) && (ra[22:0] != 23'd0);
    nan_b  = (rb[30:23] == 8'hFF) && (rb[22:0] != 23'd0);
    inf_a  = ra[30:0] == F_INF;
    inf_b  = rb[30:0] == F_INF;
    zero_a = ra[30:0] == 31'd0;
    zero_b = rb[30:0] == 31'd0;
    sig_a  = {ra[30:23] != 8'd0, ra[22:0]};
    sig_b  = {rb[30:23] != 8'd0, rb[22:0]};
    e_a    = (ra[30:23] == 8'd0) ? 12'sd1 : $signed({4'b0, ra[30:23]});
    e_b    = (rb[30:23] == 8'd0) ? 12'sd1 : $signed({4'b0, rb[30:23]});
    lz_a   = lzc24(sig_a);
    lz_b   = lzc24(sig_b);
    prod   = sig_a * sig_b;
    a_big  = ra[30:0] >= rb[30:0];
    special = 1'b0;
    spec_y  = F_QNAN;
    unique case (rop)
      FOP_ADD: begin
        if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
          special = 1'b1;
        end else if (inf_a) begin
          special = 1'b1;
          spec_y  = {sa, F_INF};
        end else if (inf_b) begin
          special = 1'b1;
          spec_y  = {sb, F_INF};
        end
      end
      FOP_MUL: begin
        if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
          special = 1'b1;
        end else if (inf_a || inf_b) begin
          special = 1'b1;
          spec_y  = {sa ^ sb, F_INF};
        end else if (zero_a || zero_b) begin
          special = 1'b1;
          spec_y  = {sa ^ sb, 31'd0};
        end
      end
      FOP_DIV: begin
        if (nan_a || nan_b || (inf_a && inf_b) || (zero_a && zero_b)) begin
          special = 1'b1;
        end else if (inf_a || zero_b) begin
          special = 1'b1;
          spec_y  = {sa ^ sb, F_INF};
        end else if (inf_b || zero_a) begin
          special = 1'b1;
          spec_y  = {sa ^ sb, 31'd0};
        end
      end
      default: special = 1'b1;
    endcase

    al_sm   = {1'b0, ssig, 25'd0};
    al_bm   = {1'b0, bsig, 25'd0};
    al_sh   = al_sm >> dsh;
    al_lost = (al_sh << dsh) != al_sm;
    al_sum  = sub ? al_bm - (al_sh | {49'd0, al_lost})
                  : al_bm + (al_sh | {49'd0, al_lost});

    dv_ge = rem >= {1'b0, nb};
    dv_r1 = dv_ge ? rem - {1'b0, nb} : rem;
    dv_q  = {q[25:0], dv_ge};

    nm_lz = lzc50(sig);

    dn_sh   = 12'(12'sd1 - ex);
    dn_v    = sig >> dn_sh;
    dn_lost = (dn_v << dn_sh) != sig;

    rd_up = sig[25] && ((|sig[24:0]) || st || sig[26]);
    rd_m  = {1'b0, sig[49:26]} + {24'd0, rd_up};
    rd_e  = ex + $signed({11'd0, rd_m[24]});
  end

  assign done = state == F_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (start) begin
            ra    <= a;
            rb    <= b;
            rop   <= op;
            state <= F_UNPACK;
          end
        end
        F_UNPACK: begin
          st   <= 1'b0;
          if (special) begin
            y     <= spec_y;
            state <= F_DONE;
          end else begin
            unique case (rop)
              FOP_ADD: begin
                sub  <= sa ^ sb;
                zsgn <= sa & sb;
                sgn  <= a_big ? sa : sb;
                bsig <= a_big ? sig_a : sig_b;
                ssig <= a_big ? sig_b : sig_a;
                ex   <= a_big ? e_a : e_b;
                dsh  <= 8'(a_big ? e_a - e_b : e_b - e_a);
                state <= F_ALIGN;
              end
              FOP_MUL: begin
                sgn   <= sa ^ sb;
                sig   <= {2'b0, prod};
                ex    <= e_a + e_b - 12'sd125;
                state <= F_NORM;
              end
              default: begin
                sgn   <= sa ^ sb;
                rem   <= {1'b0, sig_a << lz_a};
                nb    <= sig_b << lz_b;
                q     <= 27'd0;
                cnt   <= 5'd27;
                ex    <= e_a - $signed({7'd0, lz_a}) - e_b
                         + $signed({7'd0, lz_b}) + 12'sd149;
                state <= F_DIV;
              end
            endcase
          end
        end
        F_ALIGN: begin
          sig <= al_sum;
          if (al_sum == 50'd0) sgn <= zsgn;
          state <= F_NORM;
        end
        F_DIV: begin
          q   <= dv_q;
          rem <= {dv_r1[23:0], 1'b0};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            sig   <= {23'd0, dv_q};
            st    <= dv_r1 != 25'd0;
            state <= F_NORM;
          end
        end
        F_NORM: begin
          if (sig == 50'd0) begin
            y     <= {sgn, 31'd0};
            state <= F_DONE;
          end else begin
            sig   <= sig << nm_lz;
            ex    <= ex - $signed({6'd0, nm_lz}) + 12'sd1;
            state <= F_DENORM;
          end
        end
        F_DENORM: begin
          subn <= ex <= 12'sd0;
          if (ex <= 12'sd0) begin
            sig <= dn_v;
            st  <= st | dn_lost;
          end
          state <= F_ROUND;
        end
        F_ROUND: begin
          if (subn) begin
            y <= {sgn, 7'd0, rd_m[23], rd_m[22:0]};
          end else if (rd_e >= 12'sd255) begin
            y <= {sgn, F_INF};
          end else begin
            y <= {sgn, rd_e[7:0], rd_m[22:0]};
          end
          state <= F_DONE;
        end
        F_DONE: state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* dv/tb_ascii_decimal_to_float_parser.sv */
`timescale 1ns / 100ps

module tb_ascii_decimal_to_float_parser;
  import adtf_pkg::*;

  typedef enum logic [2:0] {
    ST_SPACE, ST_INT, ST_FRAC, ST_ESIGN, ST_EDIG, ST_DONE
  } scan_state_t;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned TAIL_CYCLES = 800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = '0;
  logic        last_char = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value_bits;

  logic [31:0] float_q[$];
  int unsigned n_errors = 0;
  int unsigned n_chars = 0;
  int unsigned n_numbers = 0;
  int unsigned n_cycles = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  scan_state_t scan_state;
  logic [31:0] acc_val;
  logic [31:0] frac_step;
  bit          neg_val;
  bit          neg_exp;
  int unsigned exp_val;

  ascii_decimal_to_float_parser u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_code(char_code), .last_char(last_char),
    .out_valid(out_valid), .out_ready(out_ready),
    .value_bits(value_bits)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d numbers outstanding", $time, float_q.size());
      $display("tb_ascii_decimal_to_float_parser: done, errors");
      $finish;
    end
  end

  function automatic real pow2(int k);
    real r;
    r = 1.0;
    for (int i = 0; i < k; i++) r = r * 2.0;
    for (int i = 0; i > k; i--) r = r * 0.5;
    return r;
  endfunction

  function automatic longint round_even(real x);
    longint t;
    real     d;
    t = $rtoi(x);
    d = x - t;
    if (d > 0.5 || (d == 0.5 && t[0])) t++;
    return t;
  endfunction

  function automatic bit is_nan(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  function automatic bit is_inf(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] == 0;
  endfunction

  function automatic real f32_to_real(logic [31:0] b);
    real v;
    if (b[30:23] == 0) v = b[22:0] * pow2(-149);
    else v = (b[22:0] + 8388608.0) * pow2(int'(b[30:23]) - 150);
    return b[31] ? -v : v;
  endfunction

  function automatic logic [31:0] real_to_f32(real r, bit zsign);
    bit     s;
    real    m;
    int     e;
    longint ip;
    if (r == 0.0) return {zsign, 31'd0};
    s = r < 0.0;
    m = s ? -r : r;
    e = 0;
    while (m >= 2.0) begin m = m / 2.0; e++; end
    while (m < 1.0) begin m = m * 2.0; e--; end
    if (e < -126) begin
      ip = round_even(m * pow2(e + 149));
      return {s, ip[30:0]};
    end
    ip = round_even(m * 8388608.0);
    if (ip == 64'd16777216) begin ip = 64'd8388608; e++; end
    if (e > 127) return {s, F_INF};
    return {s, 8'(e + 127), ip[22:0]};
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    bit s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return F_QNAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return F_QNAN;
      return {s, F_INF};
    end
    return real_to_f32(f32_to_real(a) * f32_to_real(b), s);
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return F_QNAN;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return F_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    return real_to_f32(f32_to_real(a) + f32_to_real(b), a[31] & b[31]);
  endfunction

  function automatic logic [31:0] f32_div(logic [31:0] a, logic [31:0] b);
    bit s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return F_QNAN;
    if (is_inf(a) && is_inf(b)) return F_QNAN;
    if (is_inf(a)) return {s, F_INF};
    if (is_inf(b)) return {s, 31'd0};
    return real_to_f32(f32_to_real(a) / f32_to_real(b), s);
  endfunction

  function automatic logic [31:0] byte_to_f32(logic [7:0] c);
    return real_to_f32(real'(c), 1'b0);
  endfunction

  task automatic clear_parser();
    scan_state = ST_SPACE;
    acc_val = F_ZERO;
    frac_step = F_TENTH;
    neg_val = 0;
    neg_exp = 0;
    exp_val = 0;
  endtask

  task automatic push_int_digit(logic [7:0] c);
    acc_val = f32_add(f32_add(f32_mul(F_TEN, acc_val), byte_to_f32(c)), F_M48);
  endtask

  task automatic push_frac_digit(logic [7:0] c);
    acc_val = f32_add(acc_val, f32_mul(byte_to_f32(c - CH_ZERO), frac_step));
    frac_step = f32_div(frac_step, F_TEN);
  endtask

  task automatic push_exp_digit(logic [7:0] c);
    exp_val = exp_val * 10 + (c - CH_ZERO);
    if (exp_val > ADTF_EXP_CAP) exp_val = ADTF_EXP_CAP;
  endtask

  task automatic scan_char(logic [7:0] c, bit fin);
    bit          dig;
    bit          ee;
    bit          sp;
    logic [31:0] p;
    logic [31:0] v;
    dig = c >= CH_ZERO && c <= CH_NINE;
    ee = c == CH_UP_E || c == CH_LO_E;
    sp = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    case (scan_state)
      ST_SPACE: begin
        if (sp) scan_state = ST_SPACE;
        else if (c == CH_MINUS) begin neg_val = 1; scan_state = ST_INT; end
        else if (c == CH_PLUS) scan_state = ST_INT;
        else if (dig) begin push_int_digit(c); scan_state = ST_INT; end
        else if (c == CH_DOT) scan_state = ST_FRAC;
        else if (ee) scan_state = ST_ESIGN;
        else scan_state = ST_DONE;
      end
      ST_INT: begin
        if (dig) push_int_digit(c);
        else if (c == CH_DOT) scan_state = ST_FRAC;
        else if (ee) scan_state = ST_ESIGN;
        else scan_state = ST_DONE;
      end
      ST_FRAC: begin
        if (dig) push_frac_digit(c);
        else if (ee) scan_state = ST_ESIGN;
        else scan_state = ST_DONE;
      end
      ST_ESIGN: begin
        if (c == CH_MINUS) begin neg_exp = 1; scan_state = ST_EDIG; end
        else if (c == CH_PLUS) scan_state = ST_EDIG;
        else if (dig) begin push_exp_digit(c); scan_state = ST_EDIG; end
        else scan_state = ST_DONE;
      end
      ST_EDIG: begin
        if (dig) push_exp_digit(c);
        else scan_state = ST_DONE;
      end
      default: scan_state = ST_DONE;
    endcase
    if (fin) begin
      p = F_ONE;
      for (int i = 0; i < exp_val; i++) p = f32_mul(p, F_TEN);
      v = neg_exp ? f32_div(acc_val, p) : f32_mul(acc_val, p);
      if (neg_val) v[31] = ~v[31];
      float_q.push_back(v);
      clear_parser();
    end
  endtask

  task automatic send_char(logic [7:0] c, bit fin);
    in_valid <= 1'b1;
    char_code <= c;
    last_char <= fin;
    do @(posedge clk); while (!in_ready);
    scan_char(c, fin);
    n_chars++;
    if (fin) n_numbers++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic string rand_digits(int lo, int hi);
    string s;
    s = "";
    repeat ($urandom_range(lo, hi)) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_number();
    string s;
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, ($urandom_range(0, 1) ? " " : "\t")};
    case ($urandom_range(0, 2))
      0: s = {s, "-"};
      1: s = {s, "+"};
      default: ;
    endcase
    s = {s, rand_digits(0, 8)};
    if ($urandom_range(0, 2) != 0) s = {s, ".", rand_digits(0, 6)};
    if ($urandom_range(0, 2) == 0) begin
      s = {s, ($urandom_range(0, 1) ? "e" : "E")};
      case ($urandom_range(0, 2))
        0: s = {s, "-"};
        1: s = {s, "+"};
        default: ;
      endcase
      s = {s, ($urandom_range(0, 9) == 0 ? rand_digits(1, 3) : rand_digits(0, 1))};
    end
    if ($urandom_range(0, 4) == 0) s = {s, string'(8'($urandom_range(1, 255)))};
    if (s.len() == 0) s = "0";
    return s;
  endfunction

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (float_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    send_text("0");
    send_text("9");
    send_text("-0");
    send_text("+1.5");
    send_text(" \t\n3.25e2");
    send_text("1e-3");
    send_text(".5");
    send_text("e5");
    send_text("E");
    send_text("1.");
    send_text("-.");
    send_text("12x34");
    send_text("7.25E+1z9");
    send_text("1e40");
    send_text("1e-45");
    send_text("-1e99");
    send_text("0e99");
    send_text("1e-99");
    send_text("999999999999999999999999999999999999999999999");
    send_text("-999999999999999999999999999999999999999999999e-99");
    send_text("0.00000000000000000000000000000000000000000001");
    send_char(8'd0, 1'b1);
    send_char(8'd200, 1'b0);
    send_char(CH_ZERO + 8'd5, 1'b1);
    send_char(8'd255, 1'b1);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned goal;
    goal = n_chars + n;
    while (n_chars < goal) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_text(rand_number());
    end
  endtask

  task automatic test_result_stall();
    hold_req = 1'b1;
    repeat (6) send_text(rand_number());
  endtask

  task automatic test_drain_pause();
    send_text("42.5e1");
    wait_drained();
    send_text("-3.5e-2");
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    test_random(120);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (float_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, value_bits);
        n_errors++;
      end else begin
        if (value_bits !== float_q[0]) begin
          $display("%0t value_bits mismatch: expected %h, actual %h",
                   $time, float_q[0], value_bits);
          n_errors++;
        end
        void'(float_q.pop_front());
      end
    end
  end

  initial begin
    clear_parser();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_result_stall();
    test_random(500);
    test_no_idle();
    in_valid <= 1'b0;
    wait_drained();
    if (float_q.size() != 0) begin
      $display("%0t %0d expected numbers never arrived", $time, float_q.size());
      n_errors++;
    end
    $display("Sent %0d characters forming %0d numbers: signs, fractions, exponents,",
             n_chars, n_numbers);
    $display("overflow, underflow, NaN, junk bytes, long output stall and drain pause.");
    if (n_errors == 0) begin
      $display("tb_ascii_decimal_to_float_parser: done, clean");
    end else begin
      $display("tb_ascii_decimal_to_float_parser: done, errors");
    end
    $finish;
  end

endmodule
